[design/prce_pkg.sv]
// Package for the power regulator command emitter.
// Holds the command descriptor, queue constants and the byte tables.
// No dependencies.
`timescale 1ns / 1ps

package prce_pkg;

    // Width of one input item field and of the threshold register
    localparam int PCT_W   = 7;
    localparam int VOLTS_W = 8;
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 5;

    // Default depth of the command queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // Threshold reset value and voltage offset
    localparam logic [VOLTS_W-1:0] THRESHOLD_RST = 8'd40;
    localparam logic [VOLTS_W-1:0] VOLTS_OFFSET  = 8'd30;

    // ASCII constants
    localparam logic [BYTE_W-1:0] ASCII_CR   = 8'h0D;
    localparam logic [3:0]        ASCII_DIGIT_HI = 4'h3;

    localparam logic [BYTE_W-1:0] ON_HEAD [6] = '{8'h41, 8'h54, 8'h2B, 8'h4F, 8'h4E, 8'h3D};
    localparam logic [BYTE_W-1:0] VS_HEAD [6] = '{8'h41, 8'h54, 8'h2B, 8'h56, 8'h53, 8'h3D};

    // Command kinds
    typedef enum logic [1:0] {
        CMD_OFF,
        CMD_VS,
        CMD_VS_ON
    } cmd_kind_t;

    // Last byte index for each command kind
    localparam logic [IDX_W-1:0] LAST_OFF   = 5'd7;
    localparam logic [IDX_W-1:0] LAST_VS    = 5'd9;
    localparam logic [IDX_W-1:0] LAST_VS_ON = 5'd17;
    // First byte of the trailing switch-on command
    localparam logic [IDX_W-1:0] ON_START   = 5'd10;

    // One queued command: kind plus the three decimal digits of the voltage
    typedef struct packed {
        cmd_kind_t  kind;
        logic [3:0] d_hun;
        logic [3:0] d_ten;
        logic [3:0] d_one;
    } cmd_desc_t;

    // "AT+ON=x\r" byte j
    function automatic logic [BYTE_W-1:0] on_byte(logic [2:0] j, logic on);
        logic [BYTE_W-1:0] b;
        if (j < 3'd6)
            b = ON_HEAD[j];
        else if (j == 3'd6)
            b = {ASCII_DIGIT_HI, 3'b000, on};
        else
            b = ASCII_CR;
        return b;
    endfunction

    // "AT+VS=ddd\r" byte j
    function automatic logic [BYTE_W-1:0] vs_byte(logic [3:0] j, cmd_desc_t c);
        logic [BYTE_W-1:0] b;
        if (j < 4'd6)
            b = VS_HEAD[j[2:0]];
        else if (j == 4'd6)
            b = {ASCII_DIGIT_HI, c.d_hun};
        else if (j == 4'd7)
            b = {ASCII_DIGIT_HI, c.d_ten};
        else if (j == 4'd8)
            b = {ASCII_DIGIT_HI, c.d_one};
        else
            b = ASCII_CR;
        return b;
    endfunction

    // Byte idx of command c
    function automatic logic [BYTE_W-1:0] cmd_byte(cmd_desc_t c, logic [IDX_W-1:0] idx);
        logic [BYTE_W-1:0] b;
        logic [IDX_W-1:0]  j;
        j = idx - ON_START;
        unique case (c.kind)
            CMD_OFF:   b = on_byte(idx[2:0], 1'b0);
            CMD_VS:    b = vs_byte(idx[3:0], c);
            CMD_VS_ON: b = (idx < ON_START) ? vs_byte(idx[3:0], c) : on_byte(j[2:0], 1'b1);
            default:   b = ASCII_CR;
        endcase
        return b;
    endfunction

    function automatic logic [IDX_W-1:0] cmd_last_idx(cmd_kind_t k);
        logic [IDX_W-1:0] r;
        unique case (k)
            CMD_OFF:   r = LAST_OFF;
            CMD_VS:    r = LAST_VS;
            CMD_VS_ON: r = LAST_VS_ON;
            default:   r = LAST_OFF;
        endcase
        return r;
    endfunction

endpackage

[design/prce_front.sv]
// Front end: accepts power transactions, computes the target voltage,
// classifies the change and pushes a command descriptor. Uses prce_pkg.
`timescale 1ns / 1ps

module prce_front
    import prce_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [VOLTS_W-1:0]  cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [PCT_W-1:0]    power_percent,
    output logic                push,
    output cmd_desc_t           push_desc,
    input  logic                q_ready
);

    logic [VOLTS_W-1:0] threshold_reg;
    logic [VOLTS_W-1:0] prev_volts_reg;
    logic [VOLTS_W-1:0] volts;
    logic               accept;
    logic               prev_on;
    logic               now_on;
    logic [6:0]         rem;
    logic [1:0]         hun;
    logic [14:0]        tens_prod;
    logic [3:0]         tens;
    logic [6:0]         ones_full;

    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;

    // Target voltage, wraps modulo 256
    assign volts = {power_percent, 1'b0} + VOLTS_OFFSET;

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            threshold_reg <= THRESHOLD_RST;
        else if (cfg_we)
            threshold_reg <= cfg_wdata;
    end

    // Voltage stored from the previous transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_volts_reg <= '0;
        else if (accept)
            prev_volts_reg <= volts;
    end

    // Decimal digits: hundreds by compare, tens by reciprocal multiply
    always_comb
    begin
        if (volts >= 8'd200)
        begin
            hun = 2'd2;
            rem = 7'(volts - 8'd200);
        end
        else if (volts >= 8'd100)
        begin
            hun = 2'd1;
            rem = 7'(volts - 8'd100);
        end
        else
        begin
            hun = 2'd0;
            rem = volts[6:0];
        end
    end

    assign tens_prod = 15'(rem) * 15'd205;
    assign tens      = tens_prod[14:11];
    assign ones_full = rem - (7'(tens) * 7'd10);

    // Classification
    assign prev_on = prev_volts_reg >= threshold_reg;
    assign now_on  = volts >= threshold_reg;

    always_comb
    begin
        push_desc.d_hun = {2'b00, hun};
        push_desc.d_ten = tens;
        push_desc.d_one = ones_full[3:0];
        push_desc.kind  = CMD_VS;
        push            = 1'b0;
        priority if (prev_on && !now_on)
        begin
            push_desc.kind = CMD_OFF;
            push           = accept;
        end
        else if (!prev_on && now_on)
        begin
            push_desc.kind = CMD_VS_ON;
            push           = accept;
        end
        else if (prev_volts_reg != volts)
        begin
            push_desc.kind = CMD_VS;
            push           = accept;
        end
    end

endmodule

[design/prce_queue.sv]
// Short command queue between the front and back ends.
// Register FIFO of cmd_desc_t entries. Uses prce_pkg.
`timescale 1ns / 1ps

module prce_queue
    import prce_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_desc_t push_desc,
    output logic      push_ready,
    input  logic      pop,
    output logic      pop_valid,
    output cmd_desc_t pop_desc
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_desc_t          entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_desc   = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_desc;
    end

endmodule

[design/prce_back.sv]
// Back end: walks one queued command byte by byte into the output register.
// Uses prce_pkg for the byte tables and command lengths.
`timescale 1ns / 1ps

module prce_back
    import prce_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  cmd_desc_t         q_desc,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] tx_byte,
    output logic              last_byte,
    output logic              pause_before
);

    cmd_desc_t          cmd_reg;
    logic               busy_reg, busy_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  byte_reg;
    logic               last_reg;
    logic               pause_reg;
    logic               advance;
    logic               is_last;

    assign advance = busy_reg && (!out_valid_reg || out_ready);
    assign is_last = idx_reg == cmd_last_idx(cmd_reg.kind);
    assign q_pop   = q_valid && (!busy_reg || (advance && is_last));

    // Sequencer control
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (q_pop)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (advance)
        begin
            busy_next = !is_last;
            idx_next  = idx_reg + 1'b1;
        end
        out_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Command and output payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
            cmd_reg <= q_desc;
        if (advance)
        begin
            byte_reg  <= cmd_byte(cmd_reg, idx_reg);
            last_reg  <= is_last;
            pause_reg <= (cmd_reg.kind == CMD_VS_ON) && (idx_reg == ON_START);
        end
    end

    assign out_valid    = out_valid_reg;
    assign tx_byte      = byte_reg;
    assign last_byte    = last_reg;
    assign pause_before = pause_reg;

endmodule

[design/power_regulator_command_emitter_core.sv]
// Power regulator command emitter, top level.
// An input transaction pushes a command into the queue; the back end pops it and
// emits one byte per cycle while m_tready is high. A command is 8, 10 or 18 bytes.
// Input transactions that cause no change push no command; the command queue
// absorbs bursts of input. Reset (rst_n, async) sets the threshold to 40, the
// stored voltage to 0 and empties queue and output.
`timescale 1ns / 1ps

module power_regulator_command_emitter_core
    import prce_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [VOLTS_W-1:0] cfg_wdata,     // on_threshold_volts
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,       // [6:0] power_percent, [7] zero
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,       // [7:0] tx_byte
    output logic               m_tlast,       // last_byte
    output logic [0:0]         m_tuser        // [0] pause_before
);

    logic      push;
    cmd_desc_t push_desc;
    logic      q_ready;
    logic      q_pop;
    logic      q_valid;
    cmd_desc_t q_desc;
    logic      pause_before;

    // Accept and classify
    prce_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .power_percent (s_tdata[PCT_W-1:0]),
        .push          (push),
        .push_desc     (push_desc),
        .q_ready       (q_ready)
    );

    // Command queue
    prce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_desc   (q_desc)
    );

    // Byte emission
    prce_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_desc       (q_desc),
        .q_pop        (q_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .tx_byte      (m_tdata),
        .last_byte    (m_tlast),
        .pause_before (pause_before)
    );

    assign m_tuser = pause_before;

endmodule
